/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/u8sd_pkg.sv */
// Types and constants for the UTF-8 stream decoder
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

    // Outcome of decoding one byte against the current sequence state
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        logic            last;
        logic [1:0]      pending;
        logic [CP_W-1:0] partial;
        logic            bad;
    } dec_t;

endpackage

/* rtl/utf8_stream_decoder_top.sv */
// UTF-8 byte stream to code point decoder, top level
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------
//  byte    | byte_valid | byte_stall | data_byte, end_of_string
//  cp      | cp_valid   | cp_stall   | code_point, last_result
//
// One byte per cycle while byte_stall is low: input register, one decode step,
// result register; each code point is offered from the result register.
// A byte that ends no sequence yields no result and never waits on cp_stall.
// A byte that yields a result holds in the input register while the result
// register is full and stalled; byte_stall follows that condition.
// rst_n clears the sequence state and both valid flags asynchronously.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_stream_decoder_top
    import u8sd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  logic [7:0]      data_byte,
    input  logic            end_of_string,
    output logic            cp_valid,
    input  logic            cp_stall,
    output logic [CP_W-1:0] code_point,
    output logic            last_result
);

    logic            s1_valid_reg;
    logic [7:0]      byte_reg;
    logic            eos_reg;

    logic [1:0]      pending_reg;
    logic [CP_W-1:0] partial_reg;
    logic            bad_reg;

    logic            out_valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            last_reg;

    dec_t            dec;
    logic            out_free;
    logic            s1_go;
    logic            s1_fire;
    logic            byte_xfer;

    always_comb
    begin
        logic            not_cont;
        logic [1:0]      pend_dec;
        logic            bad_acc;
        logic [CP_W-1:0] part_acc;

        not_cont = (byte_reg[7:6] != 2'b10);
        pend_dec = pending_reg - 2'd1;
        bad_acc  = bad_reg | not_cont;
        part_acc = bad_acc ? partial_reg : {partial_reg[CP_W-7:0], byte_reg[5:0]};

        dec.emit       = 1'b0;
        dec.code_point = REPLACEMENT_CHAR;
        dec.last       = eos_reg;
        dec.pending    = pending_reg;
        dec.partial    = partial_reg;
        dec.bad        = bad_reg;

        if (pending_reg == 2'd0)
        begin
            if (byte_reg[7] == 1'b0)
            begin
                dec.emit       = 1'b1;
                dec.code_point = {{(CP_W-8){1'b0}}, byte_reg};
            end
            else if (byte_reg[7:5] == 3'b110 || byte_reg[7:4] == 4'b1110
                     || byte_reg[7:3] == 5'b11110)
            begin
                if (eos_reg)
                begin
                    // lead cut short by the end mark
                    dec.emit    = 1'b1;
                    dec.pending = 2'd0;
                    dec.partial = '0;
                    dec.bad     = 1'b0;
                end
                else
                begin
                    dec.bad = 1'b0;
                    if (byte_reg[7:5] == 3'b110)
                    begin
                        dec.pending = 2'd1;
                        dec.partial = {{(CP_W-5){1'b0}}, byte_reg[4:0]};
                    end
                    else if (byte_reg[7:4] == 4'b1110)
                    begin
                        dec.pending = 2'd2;
                        dec.partial = {{(CP_W-4){1'b0}}, byte_reg[3:0]};
                    end
                    else
                    begin
                        dec.pending = 2'd3;
                        dec.partial = {{(CP_W-3){1'b0}}, byte_reg[2:0]};
                    end
                end
            end
            else
            begin
                // byte that cannot lead
                dec.emit = 1'b1;
            end
        end
        else
        begin
            if (pend_dec == 2'd0)
            begin
                dec.emit       = 1'b1;
                dec.code_point = bad_acc ? REPLACEMENT_CHAR : part_acc;
                dec.pending    = 2'd0;
                dec.partial    = '0;
                dec.bad        = 1'b0;
            end
            else if (eos_reg)
            begin
                dec.emit    = 1'b1;
                dec.pending = 2'd0;
                dec.partial = '0;
                dec.bad     = 1'b0;
            end
            else
            begin
                dec.pending = pend_dec;
                dec.partial = part_acc;
                dec.bad     = bad_acc;
            end
        end
    end

    assign out_free   = !out_valid_reg || !cp_stall;
    assign s1_go      = !dec.emit || out_free;
    assign s1_fire    = s1_valid_reg && s1_go;
    assign byte_stall = s1_valid_reg && !s1_go;
    assign byte_xfer  = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                pending_reg <= dec.pending;
                partial_reg <= dec.partial;
                bad_reg     <= dec.bad;
            end

            if (s1_fire && dec.emit)
                out_valid_reg <= 1'b1;
            else if (!cp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer)
        begin
            byte_reg <= data_byte;
            eos_reg  <= end_of_string;
        end
        if (s1_fire && dec.emit)
        begin
            cp_reg   <= dec.code_point;
            last_reg <= dec.last;
        end
    end

    assign cp_valid    = out_valid_reg;
    assign code_point  = cp_reg;
    assign last_result = last_reg;

    `ASSERT_IMPL(a_stall_needs_item, clk, rst_n, byte_stall, s1_valid_reg)
    `ASSERT_IMPL(a_four_byte_partial, clk, rst_n, pending_reg == 2'd3,
                 partial_reg[CP_W-1:3] == '0)
    `ASSERT_NEXT(a_eos_goes_idle, clk, rst_n, s1_fire && eos_reg, pending_reg == 2'd0)

endmodule
